@@ rtl/core/lst_pkg.sv @@
package lst_pkg;

   // Default table size.
   localparam int NUM_SLOTS_DEF = 32;

   // Field widths.
   localparam int KEY_W    = 13;
   localparam int TIME_W   = 32;
   localparam int ELAPSE_W = 16;
   localparam int RADIUS_W = 14;
   localparam int RATE_W   = 12;
   localparam int PROD_W   = ELAPSE_W + RATE_W;
   localparam int SLOT_W   = 5;
   localparam int PATH_W   = 2;

   // Operation codes of the func field.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_DECAY = 1'b1;

   // Codes of the path field.
   localparam logic [PATH_W-1:0] PATH_KEY     = 2'd0;
   localparam logic [PATH_W-1:0] PATH_EXPIRED = 2'd1;
   localparam logic [PATH_W-1:0] PATH_FORCED  = 2'd2;
   localparam logic [PATH_W-1:0] PATH_DECAY   = 2'd3;

   // One light slot as it sits in the table.
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [TIME_W-1:0]   expiry;
      logic [RADIUS_W-1:0] radius;
      logic [RATE_W-1:0]   rate;
   } slot_entry_type;

   // Compare results that the shared unit hands to the sequencer.
   typedef struct packed {
      logic key_hit;
      logic expired;
      logic radius_zero;
   } cmp_status_type;

endpackage

@@ rtl/core/light_slot_table_top.sv @@
// Channel   Direction  Ports                                        Handshake
// req       in         req_func .. req_new_decay                    req_valid / req_stall
// rsp       out        rsp_slot, rsp_path                           rsp_valid / rsp_stall
//
// Each slot takes a read state and a check state through one table read port; an
// allocate word then passes through a fill state, and a decay word adds an update state
// for each live slot with a nonzero radius (write-back of that slot).
// Reset clears the table valid bits; no clearing pass is needed.
// A finished result waits in the output register while the next word is taken in;
// the block stalls its input from acceptance until the result is loaded.
module light_slot_table_top import lst_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [KEY_W-1:0]    req_light_key,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic [ELAPSE_W-1:0] req_elapsed_ms,
   input  logic [RADIUS_W-1:0] req_new_radius,
   input  logic [TIME_W-1:0]   req_new_expiry_ms,
   input  logic [RATE_W-1:0]   req_new_decay,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [PATH_W-1:0]   rsp_path
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_UPDATE,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                match_ff, match_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic                exp_ff, exp_in;
   logic [IDX_W-1:0]    exp_idx_ff, exp_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [PATH_W-1:0]   rsp_path_ff, rsp_path_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [PATH_W-1:0]   res_path_ff, res_path_in;

   logic                func_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [ELAPSE_W-1:0] elapsed_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [TIME_W-1:0]   expiry_ff;
   logic [RATE_W-1:0]   rate_ff;

   logic                req_take;
   logic                rsp_free;
   logic                last_slot;
   logic                load_prod;
   slot_entry_type      rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   slot_entry_type      wr_data;
   cmp_status_type      status;
   logic [RADIUS_W-1:0] radius_dec;

   lst_slot_mem #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lst_alu u_alu (
      .clock      (clock),
      .entry      (rd_data),
      .key        (key_ff),
      .now_ms     (now_ff),
      .elapsed_ms (elapsed_ff),
      .load_prod  (load_prod),
      .status     (status),
      .radius_out (radius_dec)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = (idx_ff == LAST_IDX);
   assign load_prod = (state_ff == ST_CHECK);

   // Sequencer: one read and one check per slot, an update for each decayed slot, then fill or finish.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      exp_in       = exp_ff;
      exp_idx_in   = exp_idx_ff;
      res_slot_in  = res_slot_ff;
      res_path_in  = res_path_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_slot_in  = rsp_slot_ff;
      rsp_path_in  = rsp_path_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               idx_in   = '0;
               match_in = 1'b0;
               exp_in   = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (func_ff == FUNC_DECAY) begin
               if (!status.expired && !status.radius_zero) begin
                  state_in = ST_UPDATE;
               end else if (last_slot) begin
                  res_slot_in = '0;
                  res_path_in = PATH_DECAY;
                  state_in    = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               if (status.key_hit && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = idx_ff;
               end
               if (status.expired && !exp_ff) begin
                  exp_in     = 1'b1;
                  exp_idx_in = idx_ff;
               end
               if (last_slot) begin
                  state_in = ST_FILL;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_UPDATE: begin
            wr_en          = 1'b1;
            wr_data.radius = radius_dec;
            if (last_slot) begin
               res_slot_in = '0;
               res_path_in = PATH_DECAY;
               state_in    = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_FILL: begin
            wr_en          = 1'b1;
            wr_data.key    = key_ff;
            wr_data.expiry = expiry_ff;
            wr_data.radius = radius_ff;
            wr_data.rate   = rate_ff;
            if (match_ff) begin
               wr_addr     = match_idx_ff;
               res_path_in = PATH_KEY;
            end else if (exp_ff) begin
               wr_addr     = exp_idx_ff;
               res_path_in = PATH_EXPIRED;
            end else begin
               wr_addr     = '0;
               res_path_in = PATH_FORCED;
            end
            res_slot_in = SLOT_W'(wr_addr);
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_path_in  = res_path_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, scan registers and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         match_ff     <= 1'b0;
         exp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         match_ff     <= match_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      match_idx_ff <= match_idx_in;
      exp_idx_ff   <= exp_idx_in;
      res_slot_ff  <= res_slot_in;
      res_path_ff  <= res_path_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_path_ff  <= rsp_path_in;
      if (req_take) begin
         func_ff    <= req_func;
         key_ff     <= req_light_key;
         now_ff     <= req_now_ms;
         elapsed_ff <= req_elapsed_ms;
         radius_ff  <= req_new_radius;
         expiry_ff  <= req_new_expiry_ms;
         rate_ff    <= req_new_decay;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_path  = rsp_path_ff;

endmodule

@@ rtl/core/lst_slot_mem.sv @@
module lst_slot_mem import lst_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   localparam int IDX_W = $clog2(NUM_SLOTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output slot_entry_type   rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  slot_entry_type   wr_data
);

   slot_entry_type           mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]     valid_ff;
   slot_entry_type           rd_data_ff;

   // Valid bits: cleared at reset, set on the first write of an entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Table write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (valid_ff[rd_addr]) begin
         rd_data_ff <= mem[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lst_alu.sv @@
module lst_alu import lst_pkg::*; (
   input  logic                clock,
   input  slot_entry_type      entry,
   input  logic [KEY_W-1:0]    key,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [ELAPSE_W-1:0] elapsed_ms,
   input  logic                load_prod,
   output cmp_status_type      status,
   output logic [RADIUS_W-1:0] radius_out
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] radius_ext;

   // Slot compares used by both the allocate scan and the decay scan.
   always_comb begin
      status.key_hit     = (key != '0) && (entry.key == key);
      status.expired     = (entry.expiry < now_ms);
      status.radius_zero = (entry.radius == '0);
   end

   // Radius drop, registered before the saturating subtract.
   assign prod_in = PROD_W'(elapsed_ms) * PROD_W'(entry.rate);

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= prod_in;
      end
   end

   // Saturating subtract of the drop from the radius.
   assign radius_ext = PROD_W'(entry.radius);

   always_comb begin
      if (prod_ff >= radius_ext) begin
         radius_out = '0;
      end else begin
         radius_out = RADIUS_W'(radius_ext - prod_ff);
      end
   end

endmodule
